// ----- rtl/cfvm_pkg.sv -----
package cfvm_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int VEC_W        = 18;
   localparam int POS_W        = 32;
   localparam int STEP_W       = 25;
   localparam int DELTA_W      = 28;
   localparam int SAT_W        = 40;
   localparam int ANG_W        = 27;
   localparam int YAW_W        = 26;
   localparam int PITCH_W      = 24;
   localparam int CSR_W        = 24;
   localparam int MUL_A_W      = 34;
   localparam int MUL_B_W      = 18;
   localparam int ACC_W        = 52;
   localparam int RND_W        = ACC_W - FRAC_BITS;
   localparam int MOD_W        = 42;
   localparam int MOD_STEPS    = 17;
   localparam int CORDIC_STEPS = 23;
   localparam int CORDIC_XY_W  = 32;
   localparam int CORDIC_SHIFT = 30 - FRAC_BITS;

   localparam logic signed [ANG_W-1:0] DEG90       = 27'sd5898240;
   localparam logic signed [ANG_W-1:0] DEG180      = 27'sd11796480;
   localparam logic signed [ANG_W-1:0] DEG360      = 27'sd23592960;
   localparam logic signed [ANG_W-1:0] PITCH_LIMIT = 27'sd5832704;

   localparam logic signed [CORDIC_XY_W-1:0] CORDIC_GAIN = 32'sd652032874;
   localparam logic signed [CORDIC_XY_W-1:0] CORDIC_HALF = 32'sd8192;
   localparam logic signed [ACC_W-1:0]       ACC_HALF    = 52'sd32768;

   localparam logic [1:0] CSR_MOVE_SPEED = 2'd0;
   localparam logic [1:0] CSR_MOUSE_SENS = 2'd1;

   localparam logic [CSR_W-1:0] SPEED_RESET = 24'd163840;
   localparam logic [CSR_W-1:0] SENS_RESET  = 24'd6554;
   localparam logic [YAW_W-1:0] YAW_RESET   = 26'd5898240;

   localparam logic [1:0]              ROW_LAST = 2'd3;
   localparam logic signed [POS_W-1:0] ONE_Q    = 32'sd65536;

   localparam logic signed [SAT_W-1:0] S32_MAX = 40'sd2147483647;
   localparam logic signed [SAT_W-1:0] S32_MIN = -40'sd2147483648;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_YAW_MUL,
      ST_YAW_MOD,
      ST_PIT_MUL,
      ST_COR_YAW,
      ST_COR_PIT,
      ST_VEC,
      ST_STEP,
      ST_MOVE,
      ST_DOT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic accum;
   } mul_ctl_type;

   // arctangent of 2^-i in degrees, 16 fraction bits
   function automatic logic signed [ANG_W-1:0] atan_deg(input logic [4:0] i);
      case (i)
         5'd0:  return 27'sd2949120;
         5'd1:  return 27'sd1740967;
         5'd2:  return 27'sd919879;
         5'd3:  return 27'sd466945;
         5'd4:  return 27'sd234379;
         5'd5:  return 27'sd117304;
         5'd6:  return 27'sd58666;
         5'd7:  return 27'sd29335;
         5'd8:  return 27'sd14668;
         5'd9:  return 27'sd7334;
         5'd10: return 27'sd3667;
         5'd11: return 27'sd1833;
         5'd12: return 27'sd917;
         5'd13: return 27'sd458;
         5'd14: return 27'sd229;
         5'd15: return 27'sd115;
         5'd16: return 27'sd57;
         5'd17: return 27'sd29;
         5'd18: return 27'sd14;
         5'd19: return 27'sd7;
         5'd20: return 27'sd4;
         5'd21: return 27'sd2;
         5'd22: return 27'sd1;
         default: return '0;
      endcase
   endfunction

   function automatic logic signed [POS_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
      if (v > S32_MAX) return S32_MAX[POS_W-1:0];
      if (v < S32_MIN) return S32_MIN[POS_W-1:0];
      return v[POS_W-1:0];
   endfunction

   // round half up, drop the fraction bits
   function automatic logic signed [RND_W-1:0] round_acc(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] t;
      t = v + ACC_HALF;
      return t[ACC_W-1:FRAC_BITS];
   endfunction

endpackage

// ----- rtl/cfvm_mul.sv -----
module cfvm_mul (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cfvm_pkg::mul_ctl_type                 ctl,
   input  logic signed [cfvm_pkg::MUL_A_W-1:0]   a,
   input  logic signed [cfvm_pkg::MUL_B_W-1:0]   b,
   output logic                                  done,
   output logic signed [cfvm_pkg::ACC_W-1:0]     acc
);
   import cfvm_pkg::*;

   localparam logic [4:0] LAST = 5'(MUL_B_W - 1);

   logic signed [ACC_W-1:0]   a_ff, a_in, acc_ff, acc_in, pp;
   logic signed [MUL_B_W-1:0] b_ff, b_in;
   logic [4:0]                cnt_ff, cnt_in;
   logic                      run_ff, run_in, done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      pp      = b_ff[0] ? a_ff : '0;
      if (ctl.start) begin
         a_in   = ACC_W'(a);
         b_in   = b;
         cnt_in = '0;
         run_in = 1'b1;
         if (!ctl.accum) acc_in = '0;
      end else if (run_ff) begin
         // the sign bit of the multiplier weighs negative
         acc_in = (cnt_ff == LAST) ? acc_ff - pp : acc_ff + pp;
         a_in   = a_ff <<< 1;
         b_in   = b_ff >>> 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

// ----- rtl/cfvm_mod.sv -----
module cfvm_mod (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [cfvm_pkg::MOD_W-1:0]   value,
   output logic                                done,
   output logic [cfvm_pkg::YAW_W-1:0]          result
);
   import cfvm_pkg::*;

   localparam logic [MOD_W-1:0] D_BASE = MOD_W'(DEG360);
   localparam logic [MOD_W-1:0] D_TOP  = D_BASE << (MOD_STEPS - 1);
   localparam logic [4:0]       LAST   = 5'(MOD_STEPS - 1);
   localparam logic [YAW_W-1:0] D_YAW  = YAW_W'(DEG360);

   logic [MOD_W-1:0] m_ff, m_in, d_ff, d_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             neg_ff, neg_in, run_ff, run_in, done_ff, done_in;
   logic [YAW_W-1:0] r;

   always_comb begin
      m_in    = m_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         neg_in = value[MOD_W-1];
         m_in   = value[MOD_W-1] ? MOD_W'(-value) : MOD_W'(value);
         d_in   = D_TOP;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (m_ff >= d_ff) m_in = m_ff - d_ff;
         d_in   = d_ff >> 1;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      m_ff   <= m_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   // fold a negative remainder back into [0, 360)
   assign r      = m_ff[YAW_W-1:0];
   assign result = (neg_ff && r != '0) ? D_YAW - r : r;
   assign done   = done_ff;

endmodule

// ----- rtl/cfvm_cordic.sv -----
module cfvm_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [cfvm_pkg::ANG_W-1:0]   angle,
   output logic                                done,
   output logic signed [cfvm_pkg::VEC_W-1:0]   sin_out,
   output logic signed [cfvm_pkg::VEC_W-1:0]   cos_out
);
   import cfvm_pkg::*;

   localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

   logic signed [CORDIC_XY_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys, xt, yt;
   logic signed [ANG_W-1:0]       z_ff, z_in, a_f;
   logic [4:0]                    i_ff, i_in;
   logic                          neg_ff, neg_in, run_ff, run_in, done_ff, done_in, flip;
   logic signed [VEC_W-1:0]       xr, yr;

   // fold into [-90, 90]
   always_comb begin
      a_f  = angle;
      flip = 1'b0;
      if (a_f > DEG180) a_f = a_f - DEG360;
      if (a_f <= -DEG180) a_f = a_f + DEG360;
      if (a_f > DEG90) begin
         a_f  = a_f - DEG180;
         flip = 1'b1;
      end else if (a_f < -DEG90) begin
         a_f  = a_f + DEG180;
         flip = 1'b1;
      end
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      neg_in  = neg_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      xs      = x_ff >>> i_ff;
      ys      = y_ff >>> i_ff;
      if (start) begin
         x_in   = CORDIC_GAIN;
         y_in   = '0;
         z_in   = a_f;
         neg_in = flip;
         i_in   = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!z_ff[ANG_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_deg(i_ff);
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_deg(i_ff);
         end
         i_in = i_ff + 5'd1;
         if (i_ff == LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         i_ff    <= i_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   assign xt      = x_ff + CORDIC_HALF;
   assign yt      = y_ff + CORDIC_HALF;
   assign xr      = xt[CORDIC_XY_W-1:CORDIC_SHIFT];
   assign yr      = yt[CORDIC_XY_W-1:CORDIC_SHIFT];
   assign cos_out = neg_ff ? -xr : xr;
   assign sin_out = neg_ff ? -yr : yr;
   assign done    = done_ff;

endmodule

// ----- rtl/fly_camera_view_matrix_core.sv -----
// Fly camera view matrix core.
// Request channel (req_*): one frame tick per transfer, carrying mouse offsets,
// the six movement key bits and the frame time. The core updates yaw, pitch
// and position and answers with four transfers on the response channel
// (rsp_*), matrix rows 0 to 3 in order; rsp_last_row marks row 3.
// csr_write with csr_index 0 loads the move speed, index 1 the mouse
// sensitivity; other indexes are dropped. Write them only while idle.
// One tick is worked at a time: req_stall stays high from the transfer until
// the last row has been taken. All products go through one bit-serial
// multiplier, 18 multiplier bits per product; angle wrap and each
// sine/cosine pair (CORDIC) are worked by their own serial units.
// Row 0 shows once the tick has been worked, each pressed key adding work,
// then one row per cycle while rsp_stall is low. A stall holds the current
// row and its fields unchanged.
// Reset (synchronous) puts the camera at the origin, yaw 90 degrees, pitch 0,
// speed 2.5 and sensitivity 6554, with the core idle.
module fly_camera_view_matrix_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [15:0]                  req_mouse_dx,
   input  logic signed [15:0]                  req_mouse_dy,
   input  logic [5:0]                          req_key_mask,
   input  logic [15:0]                         req_frame_time,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_row_index,
   output logic signed [cfvm_pkg::POS_W-1:0]   rsp_col0,
   output logic signed [cfvm_pkg::POS_W-1:0]   rsp_col1,
   output logic signed [cfvm_pkg::POS_W-1:0]   rsp_col2,
   output logic signed [cfvm_pkg::POS_W-1:0]   rsp_col3,
   output logic                                rsp_last_row,
   input  logic                                csr_write,
   input  logic [1:0]                          csr_index,
   input  logic [cfvm_pkg::CSR_W-1:0]          csr_data
);
   import cfvm_pkg::*;

   localparam logic [1:0] GRP_FWD   = 2'd0;
   localparam logic [1:0] GRP_RIGHT = 2'd1;
   localparam logic [1:0] GRP_UP    = 2'd2;
   localparam logic [2:0] KEY_END   = 3'd6;

   state_type state_ff, state_in;

   logic [CSR_W-1:0]          speed_ff, speed_in, sens_ff, sens_in;
   logic signed [POS_W-1:0]   px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [YAW_W-1:0]          yaw_ff, yaw_in;
   logic signed [PITCH_W-1:0] pitch_ff, pitch_in;
   logic signed [15:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic [5:0]                keys_ff, keys_in;
   logic [15:0]               dt_ff, dt_in;
   logic signed [VEC_W-1:0]   cy_ff, cy_in, sy_ff, sy_in, cp_ff, cp_in, sp_ff, sp_in;
   logic signed [VEC_W-1:0]   fx_ff, fx_in, fz_ff, fz_in, ux_ff, ux_in, uz_ff, uz_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic signed [POS_W-1:0]   col3_ff [0:2];
   logic signed [POS_W-1:0]   col3_in;
   logic                      col3_we;
   logic [2:0]                idx_ff, idx_in;
   logic [1:0]                comp_ff, comp_in;
   logic                      wait_ff, wait_in;

   mul_ctl_type               mul_ctl;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic                      mul_done;
   logic signed [ACC_W-1:0]   mul_acc;
   logic                      mod_start, mod_done;
   logic signed [MOD_W-1:0]   mod_value;
   logic [YAW_W-1:0]          mod_result;
   logic                      cor_start, cor_done;
   logic signed [ANG_W-1:0]   cor_angle;
   logic signed [VEC_W-1:0]   cor_sin, cor_cos;

   logic [1:0]                grp;
   logic signed [VEC_W-1:0]   rx, vsel, rv;
   logic signed [POS_W-1:0]   posc, newp;
   logic signed [RND_W-1:0]   rnd;
   logic signed [DELTA_W-1:0] delta;
   logic signed [MOD_W-1:0]   pit_sum;
   logic                      move_neg;

   cfvm_mul u_mul (
      .clock (clock),
      .reset (reset),
      .ctl   (mul_ctl),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .acc   (mul_acc)
   );

   cfvm_mod u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .value  (mod_value),
      .done   (mod_done),
      .result (mod_result)
   );

   cfvm_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .done    (cor_done),
      .sin_out (cor_sin),
      .cos_out (cor_cos)
   );

   assign rx = -sy_ff;

   // direction vector and position component for the move and dot phases
   always_comb begin
      if (state_ff == ST_DOT) begin
         case (idx_ff[1:0])
            2'd0:    grp = GRP_RIGHT;
            2'd1:    grp = GRP_UP;
            default: grp = GRP_FWD;
         endcase
      end else begin
         case (idx_ff[2:1])
            2'd0:    grp = GRP_FWD;
            2'd1:    grp = GRP_RIGHT;
            default: grp = GRP_UP;
         endcase
      end
      case (grp)
         GRP_FWD: begin
            case (comp_ff)
               2'd0:    vsel = fx_ff;
               2'd1:    vsel = sp_ff;
               default: vsel = fz_ff;
            endcase
         end
         GRP_RIGHT: begin
            case (comp_ff)
               2'd0:    vsel = rx;
               2'd1:    vsel = '0;
               default: vsel = cy_ff;
            endcase
         end
         default: begin
            case (comp_ff)
               2'd0:    vsel = ux_ff;
               2'd1:    vsel = cp_ff;
               default: vsel = uz_ff;
            endcase
         end
      endcase
      case (comp_ff)
         2'd0:    posc = px_ff;
         2'd1:    posc = py_ff;
         default: posc = pz_ff;
      endcase
   end

   assign rnd      = round_acc(mul_acc);
   assign rv       = rnd[VEC_W-1:0];
   assign delta    = rnd[DELTA_W-1:0];
   assign move_neg = (idx_ff == 3'd1) || (idx_ff == 3'd3) || (idx_ff == 3'd4);
   assign newp     = sat32(move_neg ? SAT_W'(posc) - SAT_W'(delta)
                                    : SAT_W'(posc) + SAT_W'(delta));
   assign pit_sum  = MOD_W'(pitch_ff) + mul_acc[MOD_W-1:0];

   always_comb begin
      state_in  = state_ff;
      speed_in  = speed_ff;
      sens_in   = sens_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      pz_in     = pz_ff;
      yaw_in    = yaw_ff;
      pitch_in  = pitch_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      keys_in   = keys_ff;
      dt_in     = dt_ff;
      cy_in     = cy_ff;
      sy_in     = sy_ff;
      cp_in     = cp_ff;
      sp_in     = sp_ff;
      fx_in     = fx_ff;
      fz_in     = fz_ff;
      ux_in     = ux_ff;
      uz_in     = uz_ff;
      step_in   = step_ff;
      idx_in    = idx_ff;
      comp_in   = comp_ff;
      wait_in   = wait_ff;
      col3_in   = '0;
      col3_we   = 1'b0;
      mul_ctl   = '0;
      mul_a     = '0;
      mul_b     = '0;
      mod_start = 1'b0;
      mod_value = MOD_W'({1'b0, yaw_ff}) - mul_acc[MOD_W-1:0];
      cor_start = 1'b0;
      cor_angle = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;

      if (csr_write) begin
         case (csr_index)
            CSR_MOVE_SPEED: speed_in = csr_data;
            CSR_MOUSE_SENS: sens_in  = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dx_in    = req_mouse_dx;
               dy_in    = req_mouse_dy;
               keys_in  = req_key_mask;
               dt_in    = req_frame_time;
               idx_in   = '0;
               comp_in  = '0;
               wait_in  = 1'b0;
               state_in = ST_YAW_MUL;
            end
         end
         ST_YAW_MUL: begin
            mul_a = MUL_A_W'(sens_ff);
            mul_b = MUL_B_W'(dx_ff);
            mul_ctl.start = !wait_ff;
            if (!wait_ff) wait_in = 1'b1;
            if (mul_done) begin
               wait_in  = 1'b0;
               state_in = ST_YAW_MOD;
            end
         end
         ST_YAW_MOD: begin
            mod_start = !wait_ff;
            if (!wait_ff) wait_in = 1'b1;
            if (mod_done) begin
               yaw_in   = mod_result;
               wait_in  = 1'b0;
               state_in = ST_PIT_MUL;
            end
         end
         ST_PIT_MUL: begin
            mul_a = MUL_A_W'(sens_ff);
            mul_b = MUL_B_W'(dy_ff);
            mul_ctl.start = !wait_ff;
            if (!wait_ff) wait_in = 1'b1;
            if (mul_done) begin
               if (pit_sum > MOD_W'(PITCH_LIMIT)) pitch_in = PITCH_W'(PITCH_LIMIT);
               else if (pit_sum < -MOD_W'(PITCH_LIMIT)) pitch_in = PITCH_W'(-PITCH_LIMIT);
               else pitch_in = pit_sum[PITCH_W-1:0];
               wait_in  = 1'b0;
               state_in = ST_COR_YAW;
            end
         end
         ST_COR_YAW: begin
            cor_angle = ANG_W'({1'b0, yaw_ff});
            cor_start = !wait_ff;
            if (!wait_ff) wait_in = 1'b1;
            if (cor_done) begin
               cy_in    = cor_cos;
               sy_in    = cor_sin;
               wait_in  = 1'b0;
               state_in = ST_COR_PIT;
            end
         end
         ST_COR_PIT: begin
            cor_angle = ANG_W'(pitch_ff);
            cor_start = !wait_ff;
            if (!wait_ff) wait_in = 1'b1;
            if (cor_done) begin
               cp_in    = cor_cos;
               sp_in    = cor_sin;
               wait_in  = 1'b0;
               idx_in   = '0;
               state_in = ST_VEC;
            end
         end
         ST_VEC: begin
            mul_a = MUL_A_W'(idx_ff[0] ? sy_ff : cy_ff);
            mul_b = idx_ff[1] ? sp_ff : cp_ff;
            mul_ctl.start = !wait_ff;
            if (!wait_ff) wait_in = 1'b1;
            if (mul_done) begin
               case (idx_ff[1:0])
                  2'd0:    fx_in = rv;
                  2'd1:    fz_in = rv;
                  2'd2:    ux_in = -rv;
                  default: uz_in = -rv;
               endcase
               wait_in = 1'b0;
               if (idx_ff[1:0] == 2'd3) begin
                  idx_in   = '0;
                  state_in = ST_STEP;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         ST_STEP: begin
            mul_a = MUL_A_W'(speed_ff);
            mul_b = MUL_B_W'(dt_ff);
            mul_ctl.start = !wait_ff;
            if (!wait_ff) wait_in = 1'b1;
            if (mul_done) begin
               step_in  = rnd[STEP_W-1:0];
               wait_in  = 1'b0;
               idx_in   = '0;
               comp_in  = '0;
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            mul_a = MUL_A_W'(step_ff);
            mul_b = vsel;
            if (!wait_ff) begin
               if (idx_ff == KEY_END) begin
                  idx_in   = '0;
                  comp_in  = '0;
                  state_in = ST_DOT;
               end else if (!keys_ff[idx_ff]) begin
                  idx_in = idx_ff + 3'd1;       // skip a released key
               end else begin
                  mul_ctl.start = 1'b1;
                  wait_in       = 1'b1;
               end
            end
            if (mul_done) begin
               case (comp_ff)
                  2'd0:    px_in = newp;
                  2'd1:    py_in = newp;
                  default: pz_in = newp;
               endcase
               wait_in = 1'b0;
               if (comp_ff == 2'd2) begin
                  comp_in = '0;
                  idx_in  = idx_ff + 3'd1;
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end
         end
         ST_DOT: begin
            mul_a = MUL_A_W'(posc);
            mul_b = vsel;
            mul_ctl.accum = (comp_ff != 2'd0);
            mul_ctl.start = !wait_ff;
            if (!wait_ff) wait_in = 1'b1;
            if (mul_done) begin
               wait_in = 1'b0;
               if (comp_ff == 2'd2) begin
                  col3_we = 1'b1;
                  col3_in = (idx_ff[1:0] == 2'd2) ? sat32(SAT_W'(rnd)) : sat32(-SAT_W'(rnd));
                  comp_in = '0;
                  if (idx_ff[1:0] == 2'd2) begin
                     idx_in   = '0;
                     state_in = ST_OUT;
                  end else begin
                     idx_in = idx_ff + 3'd1;
                  end
               end else begin
                  comp_in = comp_ff + 2'd1;
               end
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (idx_ff[1:0] == ROW_LAST) state_in = ST_IDLE;
               else idx_in = idx_ff + 3'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         speed_ff <= SPEED_RESET;
         sens_ff  <= SENS_RESET;
         px_ff    <= '0;
         py_ff    <= '0;
         pz_ff    <= '0;
         yaw_ff   <= YAW_RESET;
         pitch_ff <= '0;
         idx_ff   <= '0;
         comp_ff  <= '0;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         speed_ff <= speed_in;
         sens_ff  <= sens_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
         pz_ff    <= pz_in;
         yaw_ff   <= yaw_in;
         pitch_ff <= pitch_in;
         idx_ff   <= idx_in;
         comp_ff  <= comp_in;
         wait_ff  <= wait_in;
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      keys_ff <= keys_in;
      dt_ff   <= dt_in;
      cy_ff   <= cy_in;
      sy_ff   <= sy_in;
      cp_ff   <= cp_in;
      sp_ff   <= sp_in;
      fx_ff   <= fx_in;
      fz_ff   <= fz_in;
      ux_ff   <= ux_in;
      uz_ff   <= uz_in;
      step_ff <= step_in;
      if (col3_we) col3_ff[idx_ff[1:0]] <= col3_in;
   end

   // row select for the response fields
   always_comb begin
      rsp_row_index = idx_ff[1:0];
      rsp_last_row  = (idx_ff[1:0] == ROW_LAST);
      case (idx_ff[1:0])
         2'd0: begin
            rsp_col0 = POS_W'(rx);
            rsp_col1 = '0;
            rsp_col2 = POS_W'(cy_ff);
            rsp_col3 = col3_ff[0];
         end
         2'd1: begin
            rsp_col0 = POS_W'(ux_ff);
            rsp_col1 = POS_W'(cp_ff);
            rsp_col2 = POS_W'(uz_ff);
            rsp_col3 = col3_ff[1];
         end
         2'd2: begin
            rsp_col0 = -POS_W'(fx_ff);
            rsp_col1 = -POS_W'(sp_ff);
            rsp_col2 = -POS_W'(fz_ff);
            rsp_col3 = col3_ff[2];
         end
         default: begin
            rsp_col0 = '0;
            rsp_col1 = '0;
            rsp_col2 = '0;
            rsp_col3 = ONE_Q;
         end
      endcase
   end

endmodule

// ----- rtl/cfvm_props.sv -----
module cfvm_props (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [1:0]                          rsp_row_index,
   input logic signed [cfvm_pkg::POS_W-1:0]   rsp_col0,
   input logic signed [cfvm_pkg::POS_W-1:0]   rsp_col1,
   input logic signed [cfvm_pkg::POS_W-1:0]   rsp_col2,
   input logic signed [cfvm_pkg::POS_W-1:0]   rsp_col3,
   input logic                                rsp_last_row
);
   import cfvm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row_index) && $stable(rsp_col3))
      else $error("response changed while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while rows pending");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_row == (rsp_row_index == ROW_LAST))
      else $error("last row flag mismatch");

   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_row |=>
         rsp_valid && rsp_row_index == $past(rsp_row_index) + 2'd1)
      else $error("rows out of order");

   a_row3: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_row |->
         rsp_col0 == '0 && rsp_col1 == '0 && rsp_col2 == '0 && rsp_col3 == ONE_Q)
      else $error("bad homogeneous row");

endmodule

bind fly_camera_view_matrix_core cfvm_props u_props (.*);

// ----- bench/tb_fly_camera_view_matrix_core.sv -----
module tb_fly_camera_view_matrix_core;
   timeunit 1ns;
   timeprecision 1ps;
   import cfvm_pkg::*;

   typedef struct {
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic [5:0]         keys;
      logic [15:0]        dt;
   } tick_type;

   typedef struct {
      logic [1:0]         row;
      logic signed [31:0] c0, c1, c2, c3;
      logic               last;
   } row_type;

   // indexes past the register list, expected to be dropped
   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [15:0] req_mouse_dx = 0, req_mouse_dy = 0;
   logic [5:0] req_key_mask = 0;
   logic [15:0] req_frame_time = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [1:0] rsp_row_index;
   logic signed [31:0] rsp_col0, rsp_col1, rsp_col2, rsp_col3;
   logic rsp_last_row;
   logic csr_write = 0;
   logic [1:0] csr_index = CSR_MOVE_SPEED;
   logic [CSR_W-1:0] csr_data = 0;

   fly_camera_view_matrix_core uut (.*);

   initial forever #5 clock = ~clock;

   tick_type pending_ticks[$];
   row_type  expected_rows[$];
   int    errors = 0;
   int    rows_seen = 0;
   int    ticks_sent = 0;
   int    send_idle_pct = 0;
   int    recv_idle_pct = 0;
   int    hold_len = 0;
   int    hold_off = 0;
   bit    hold_used = 0;
   longint cycle_count = 0;

   // camera model state
   longint cam_speed = SPEED_RESET, cam_sens = SENS_RESET;
   longint cam_yaw = 5898240, cam_pitch = 0;
   longint cam_px = 0, cam_py = 0, cam_pz = 0;

   localparam longint ATAN_TAB[23] = '{2949120, 1740967, 919879, 466945, 234379,
      117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
      14, 7, 4, 2, 1};

   function automatic longint rnd_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return rnd_shift(a * b, 16);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   task automatic cordic_deg(input longint a, output longint s, output longint c);
      longint x, y, z, xs, ys;
      bit neg;
      neg = 0;
      x = 652032874;
      y = 0;
      if (a > 11796480) a -= 23592960;
      if (a <= -11796480) a += 23592960;
      if (a > 5898240) begin
         a -= 11796480;
         neg = 1;
      end else if (a < -5898240) begin
         a += 11796480;
         neg = 1;
      end
      z = a;
      for (int i = 0; i < 23; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= ATAN_TAB[i];
         end else begin
            x += ys; y -= xs; z += ATAN_TAB[i];
         end
      end
      x = rnd_shift(x, 14);
      y = rnd_shift(y, 14);
      c = neg ? -x : x;
      s = neg ? -y : y;
   endtask

   task automatic move_cam(longint stp, longint sgn, longint vx, longint vy, longint vz);
      cam_px = clamp32(cam_px + sgn * qmul(stp, vx));
      cam_py = clamp32(cam_py + sgn * qmul(stp, vy));
      cam_pz = clamp32(cam_pz + sgn * qmul(stp, vz));
   endtask

   function automatic row_type make_row(int r, longint a, longint b, longint c, longint d);
      row_type o;
      o.row = r[1:0];
      o.c0 = 32'(clamp32(a));
      o.c1 = 32'(clamp32(b));
      o.c2 = 32'(clamp32(c));
      o.c3 = 32'(clamp32(d));
      o.last = (r == 3);
      return o;
   endfunction

   task automatic predict_view(input tick_type t);
      longint y, p, cy, sy, cp, sp, stp, fx, fy, fz, rx, rz, ux, uy, uz;
      y = (cam_yaw - longint'(t.dx) * cam_sens) % 23592960;
      if (y < 0) y += 23592960;
      cam_yaw = y;
      p = cam_pitch + longint'(t.dy) * cam_sens;
      if (p > 5832704) p = 5832704;
      if (p < -5832704) p = -5832704;
      cam_pitch = p;
      cordic_deg(y, sy, cy);
      cordic_deg(p, sp, cp);
      fx = qmul(cy, cp); fy = sp; fz = qmul(sy, cp);
      rx = -sy; rz = cy;
      ux = -qmul(cy, sp); uy = cp; uz = -qmul(sy, sp);
      stp = rnd_shift(cam_speed * longint'(t.dt), 16);
      if (t.keys[0]) move_cam(stp, 1, fx, fy, fz);
      if (t.keys[1]) move_cam(stp, -1, fx, fy, fz);
      if (t.keys[2]) move_cam(stp, 1, rx, 0, rz);
      if (t.keys[3]) move_cam(stp, -1, rx, 0, rz);
      if (t.keys[4]) move_cam(stp, -1, ux, uy, uz);
      if (t.keys[5]) move_cam(stp, 1, ux, uy, uz);
      expected_rows.push_back(make_row(0, rx, 0, rz,
         -rnd_shift(rx * cam_px + rz * cam_pz, 16)));
      expected_rows.push_back(make_row(1, ux, uy, uz,
         -rnd_shift(ux * cam_px + uy * cam_py + uz * cam_pz, 16)));
      expected_rows.push_back(make_row(2, -fx, -fy, -fz,
         rnd_shift(fx * cam_px + fy * cam_py + fz * cam_pz, 16)));
      expected_rows.push_back(make_row(3, 0, 0, 0, 65536));
   endtask

   // driver
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_view(pending_ticks.pop_front());
            ticks_sent <= ticks_sent + 1;
         end
         // hold a stalled payload, otherwise offer the next tick or idle
         if (!req_valid || !req_stall) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1;
               req_mouse_dx <= pending_ticks[0].dx;
               req_mouse_dy <= pending_ticks[0].dy;
               req_key_mask <= pending_ticks[0].keys;
               req_frame_time <= pending_ticks[0].dt;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_off > 0) begin
            rsp_stall <= 1;
            hold_off <= hold_off - 1;
         end else if (hold_len != 0 && !hold_used) begin
            rsp_stall <= 1;
            hold_off <= hold_len - 1;
            hold_used <= 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      row_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         rows_seen <= rows_seen + 1;
         if (expected_rows.size() == 0) begin
            $display("%0t: unexpected row %0d (no expectation pending)", $time, rsp_row_index);
            errors <= errors + 1;
         end else begin
            e = expected_rows.pop_front();
            if (e.row !== rsp_row_index || e.c0 !== rsp_col0 || e.c1 !== rsp_col1 ||
                e.c2 !== rsp_col2 || e.c3 !== rsp_col3 || e.last !== rsp_last_row) begin
               $display("%0t: row mismatch exp row=%0d %0d %0d %0d %0d last=%0d",
                        $time, e.row, e.c0, e.c1, e.c2, e.c3, e.last);
               $display("%0t:              got row=%0d %0d %0d %0d %0d last=%0d",
                        $time, rsp_row_index, rsp_col0, rsp_col1, rsp_col2, rsp_col3,
                        rsp_last_row);
               errors <= errors + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > 3000000) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic add_tick(int dx, int dy, int keys, int dt);
      tick_type t;
      t.dx = 16'(dx); t.dy = 16'(dy); t.keys = 6'(keys); t.dt = 16'(dt);
      pending_ticks.push_back(t);
   endtask

   task automatic add_random(int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: add_tick($urandom, $urandom, $urandom, $urandom);
            1: add_tick($urandom_range(200) - 100, $urandom_range(200) - 100,
                        $urandom_range(63), $urandom_range(4000));
            2: add_tick($urandom_range(1) ? 32767 : -32768, $urandom, $urandom, 16'hFFFF);
            default: add_tick($urandom_range(20) - 10, $urandom_range(2000) - 1000,
                              1 << $urandom_range(5), $urandom);
         endcase
      end
   endtask

   task automatic drain;
      while (pending_ticks.size() != 0 || req_valid || expected_rows.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [CSR_W-1:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      if (idx == CSR_MOVE_SPEED) cam_speed = val;
      else if (idx == CSR_MOUSE_SENS) cam_sens = val;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: each key alone, extremes, pitch clamp both ways, no movement
      add_tick(0, 0, 0, 0);
      for (int k = 0; k < 6; k++) add_tick(0, 0, 1 << k, 16'h8000);
      add_tick(32767, 32767, 6'h3F, 16'hFFFF);
      add_tick(-32768, -32768, 6'h03, 16'hFFFF);
      add_tick(-32768, 32767, 6'h0C, 16'hFFFF);
      add_tick(100, 0, 6'h30, 0);
      add_tick(0, -1, 6'h15, 1);
      add_tick(-1, 1, 6'h2A, 16'h5555);
      add_tick(0, 0, 6'h01, 16'hAAAA);
      send_idle_pct = 15; recv_idle_pct = 68;
      drain();
      write_reg(CSR_MOVE_SPEED, 24'hFFFFFF);
      write_reg(CSR_MOUSE_SENS, 24'hFFFFFF);
      write_reg(CSR_SPARE_A, 24'h123456);
      write_reg(CSR_SPARE_B, 24'hABCDEF);
      add_tick(1, 1, 6'h01, 16'hFFFF);
      for (int i = 0; i < 40; i++) add_tick($urandom, $urandom, 6'h01, 16'hFFFF);
      add_random(30);
      // long receiver hold-off while the sender keeps offering
      hold_len = 3000;
      drain();
      write_reg(CSR_MOVE_SPEED, '0);
      write_reg(CSR_MOUSE_SENS, '0);
      send_idle_pct = 68; recv_idle_pct = 15;
      add_random(40);
      drain();
      write_reg(CSR_MOVE_SPEED, CSR_W'($urandom_range(24'hFFFFFF)));
      write_reg(CSR_MOUSE_SENS, CSR_W'($urandom_range(20000)));
      add_random(60);
      drain();
      write_reg(CSR_MOVE_SPEED, SPEED_RESET);
      write_reg(CSR_MOUSE_SENS, SENS_RESET);
      send_idle_pct = 0; recv_idle_pct = 0;
      add_random(85);
      drain();
      $display("Covered %0d frame ticks and %0d matrix rows across five register settings,",
               ticks_sent, rows_seen);
      $display("with sender and receiver idling, a long receive hold-off and saturating moves.");
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
